@@ rtl/core/cel_pkg.sv @@
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types and operation codes of the compacting entry list.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam logic [1:0] OP_APPEND       = 2'd0;
  localparam logic [1:0] OP_UPDATE       = 2'd1;
  localparam logic [1:0] OP_REMOVE_VALUE = 2'd2;
  localparam logic [1:0] OP_REMOVE_INDEX = 2'd3;

  // request payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot_index;
    logic [31:0] entry_value;
  } cel_in_t;

  // result payload
  typedef struct packed {
    logic       ok;
    logic [4:0] entry_count;
  } cel_out_t;

  // token that walks the row of cells, one cell a cycle
  typedef struct packed {
    logic        active;
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] value;
    logic        shift;  // gap opened at or before this cell
    logic        ok;
  } cel_tok_t;

endpackage

@@ rtl/core/cel_cell.sv @@
// ----------------------------------------------------------------------------
// cel_cell
// One list slot: acts on the passing token and hands it to the next slot.
// ----------------------------------------------------------------------------
module cel_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cel_pkg::cel_tok_t tok_i,
  output cel_pkg::cel_tok_t tok_o,
  input  logic [CW-1:0]     count_i,
  input  logic [31:0]       nbr_i,
  output logic [31:0]       entry_o
);

  logic [31:0]       entry_r, entry_nxt;
  cel_pkg::cel_tok_t tok_r, tok_nxt;
  logic              in_range, at_end, at_slot, hit, shift_here, wr;

  assign in_range = CW'(IDX) < count_i;
  assign at_end   = CW'(IDX) == count_i;
  assign at_slot  = (CW + 4)'(IDX) == (CW + 4)'(tok_i.slot);

  always_comb begin
    hit        = 1'b0;
    wr         = 1'b0;
    shift_here = 1'b0;
    unique case (tok_i.op)
      cel_pkg::OP_APPEND: begin
        wr = at_end;
      end
      cel_pkg::OP_UPDATE: begin
        wr = at_slot && in_range;
      end
      cel_pkg::OP_REMOVE_VALUE: begin
        hit        = !tok_i.shift && in_range && (entry_r == tok_i.value);
        shift_here = tok_i.shift || hit;
      end
      cel_pkg::OP_REMOVE_INDEX: begin
        hit        = !tok_i.shift && in_range && at_slot;
        shift_here = tok_i.shift || hit;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    entry_nxt = entry_r;
    if (tok_i.active && wr) begin
      entry_nxt = tok_i.value;
    end else if (tok_i.active && shift_here && in_range) begin
      // close the gap: take the neighbour's entry before the token reaches it
      entry_nxt = nbr_i;
    end

    tok_nxt       = tok_i;
    tok_nxt.shift = shift_here;
    tok_nxt.ok    = tok_i.ok || wr || hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    entry_r     <= entry_nxt;
    tok_r.op    <= tok_nxt.op;
    tok_r.slot  <= tok_nxt.slot;
    tok_r.value <= tok_nxt.value;
    tok_r.shift <= tok_nxt.shift;
    tok_r.ok    <= tok_nxt.ok;
  end

  assign tok_o   = tok_r;
  assign entry_o = entry_r;

endmodule

@@ rtl/core/cel_ctrl.sv @@
// ----------------------------------------------------------------------------
// cel_ctrl
// Handshake, count register, token launch and result register.
// ----------------------------------------------------------------------------
module cel_ctrl #(
  parameter int CW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cel_pkg::cel_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cel_pkg::cel_out_t out_data,
  output cel_pkg::cel_tok_t tok_o,
  input  cel_pkg::cel_tok_t tok_i,
  output logic [CW-1:0]     count_o
);

  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  cel_pkg::cel_out_t out_r, out_nxt;
  cel_pkg::cel_tok_t start_r, start_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW+4:0]     count_ext;
  logic              accept, done;

  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign done     = tok_i.active;

  always_comb begin
    count_nxt = count_r;
    if (done && tok_i.ok) begin
      priority if (tok_i.op == cel_pkg::OP_APPEND) begin
        count_nxt = count_r + CW'(1);
      end else if (tok_i.op == cel_pkg::OP_REMOVE_VALUE ||
                   tok_i.op == cel_pkg::OP_REMOVE_INDEX) begin
        count_nxt = count_r - CW'(1);
      end else begin
        count_nxt = count_r;
      end
    end
    count_ext = (CW + 5)'(count_nxt);

    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (done) begin
      out_valid_nxt       = 1'b1;
      out_nxt.ok          = tok_i.ok;
      out_nxt.entry_count = count_ext[4:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    start_nxt.active = accept;
    start_nxt.op     = in_data.operation;
    start_nxt.slot   = in_data.slot_index;
    start_nxt.value  = in_data.entry_value;
    start_nxt.shift  = 1'b0;
    start_nxt.ok     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      count_r        <= '0;
      start_r.active <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      out_valid_r    <= out_valid_nxt;
      count_r        <= count_nxt;
      start_r.active <= start_nxt.active;
    end
    out_r         <= out_nxt;
    start_r.op    <= start_nxt.op;
    start_r.slot  <= start_nxt.slot;
    start_r.value <= start_nxt.value;
    start_r.shift <= start_nxt.shift;
    start_r.ok    <= start_nxt.ok;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign tok_o     = start_r;
  assign count_o   = count_r;

endmodule

@@ rtl/core/compacting_entry_list_top.sv @@
// ----------------------------------------------------------------------------
// compacting_entry_list_top
// Ordered list of up to CAPACITY 32-bit keys held in a row of cells, with
// append, update, remove by value and remove by index.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      into       in_valid / in_stall   cel_in_t  (operation, slot, value)
//  out_     out of     out_valid / out_stall cel_out_t (ok, entry_count)
//
// - each request launches one token that walks the cells, one cell a cycle;
//   it is registered at launch and in each cell, then in the result register
// - one request in flight: a new request waits until the token has walked
//   the whole length of the cell row
// - a removal shifts each later slot down as the token passes it
// - reset clears the count and the control state only; slot contents are
//   not cleared and need no clearing pass
// - the result waits in its register under out_stall; a new request is
//   taken once the token has left the row and no stalled result is waiting
//
module compacting_entry_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cel_pkg::cel_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cel_pkg::cel_out_t out_data
);

  // count runs 0 .. CAPACITY
  localparam int CW = $clog2(CAPACITY + 1);

  cel_pkg::cel_tok_t tok_w   [CAPACITY+1];
  logic [31:0]       entry_w [CAPACITY];
  logic [31:0]       nbr_w   [CAPACITY];
  logic [CW-1:0]     count_w;

  // control: handshake, count, token launch, result register
  cel_ctrl #(
    .CW (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .tok_o     (tok_w[0]),
    .tok_i     (tok_w[CAPACITY]),
    .count_o   (count_w)
  );

  // row of cells; slot k feeds slot k-1 when a gap is closed
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == CAPACITY - 1) begin : g_tail
      // the last slot has no neighbour above and keeps its own entry
      assign nbr_w[k] = entry_w[k];
    end else begin : g_body
      assign nbr_w[k] = entry_w[k+1];
    end

    cel_cell #(
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok_w[k]),
      .tok_o   (tok_w[k+1]),
      .count_i (count_w),
      .nbr_i   (nbr_w[k]),
      .entry_o (entry_w[k])
    );
  end

endmodule

@@ rtl/core/cel_checker.sv @@
// ----------------------------------------------------------------------------
// cel_checker
// Port-level checks of the compacting entry list, bound to the top level.
// ----------------------------------------------------------------------------
module cel_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input cel_pkg::cel_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input cel_pkg::cel_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // one request in flight: after a request is taken the input stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // results never come back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result followed at once by another");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind compacting_entry_list_top cel_checker u_cel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
